[src/rfda_pkg.sv]
// ----------------------------------------------------------------------------
// rfda_pkg
// Shared types and constants for the radar frame distance averager.
// ----------------------------------------------------------------------------
`default_nettype none

package rfda_pkg;

	// frame layout
	localparam int unsigned PAYLOAD_LEN = 8;
	localparam int unsigned PosW        = $clog2(PAYLOAD_LEN + 1);

	localparam logic [7:0] HDR_BYTE  = 8'hAA;
	localparam logic [7:0] END_BYTE  = 8'h55;
	localparam logic [7:0] DIST_ID_A = 8'h0C;
	localparam logic [7:0] DIST_ID_B = 8'h07;

	// payload byte positions used by a distance frame
	localparam logic [PosW-1:0] POS_KIND = PosW'(0);
	localparam logic [PosW-1:0] POS_DHI  = PosW'(2);
	localparam logic [PosW-1:0] POS_DLO  = PosW'(3);
	localparam logic [PosW-1:0] POS_LAST = PosW'(PAYLOAD_LEN - 1);

	localparam logic [7:0] CNT_FULL = 8'hFF;

	// divider: 24-bit sum shifted by 8 fraction bits
	localparam int unsigned SumW  = 24;
	localparam int unsigned CntW  = 8;
	localparam int unsigned DvdW  = SumW + 8;
	localparam int unsigned StepW = $clog2(DvdW);

	typedef enum logic [2:0] {
		PH_HDR1,
		PH_HDR2,
		PH_ID1,
		PH_ID2,
		PH_PAY,
		PH_END1,
		PH_END2
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} back_state_t;

	// totals of one finished batch
	typedef struct packed {
		logic [CntW-1:0] count;
		logic [SumW-1:0] sum;
	} batch_t;

	// queue status seen by the front and back
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

`default_nettype wire

[src/rfda_in_if.sv]
// ----------------------------------------------------------------------------
// rfda_in_if
// Byte channel from the serial receiver: valid/ready with byte and batch flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfda_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       batch_end;

	modport source (output valid, output rx_byte, output batch_end, input ready);
	modport sink (input valid, input rx_byte, input batch_end, output ready);
endinterface

`default_nettype wire

[src/rfda_out_if.sv]
// ----------------------------------------------------------------------------
// rfda_out_if
// Result channel: one item per batch with valid flag, mean and frame count.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfda_out_if;
	logic        valid;
	logic        ready;
	logic        reading_valid;
	logic [23:0] mean_distance_q8;
	logic [7:0]  frames_used;

	modport source (output valid, output reading_valid, output mean_distance_q8,
		output frames_used, input ready);
	modport sink (input valid, input reading_valid, input mean_distance_q8,
		input frames_used, output ready);
endinterface

`default_nettype wire

[src/rfda_front.sv]
// ----------------------------------------------------------------------------
// rfda_front
// Frame parser and batch accumulator. Takes one byte per cycle while the queue is
// not full and pushes the batch totals into the queue on a batch-end byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rfda_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	rfda_in_if.sink                  in,
	input  wire rfda_pkg::qstat_t    qstat,
	output logic                     push,
	output rfda_pkg::batch_t         push_data
);

	rfda_pkg::phase_t               phase_q, phase_nxt;
	logic [7:0]                     id1_q, id2_q;
	logic [7:0]                     kind_q, dhi_q, dlo_q;
	logic [rfda_pkg::PosW-1:0]      pos_q;
	logic [rfda_pkg::SumW-1:0]      sum_q, sum_nxt;
	logic [rfda_pkg::CntW-1:0]      cnt_q, cnt_nxt;
	logic                           accept;
	logic                           hit;

	assign in.ready = !qstat.full;
	assign accept   = in.valid && in.ready;

	// distance frame completes on a good second end byte
	assign hit = (phase_q == rfda_pkg::PH_END2) && (in.rx_byte == rfda_pkg::END_BYTE)
		&& (id1_q == rfda_pkg::DIST_ID_A) && (id2_q == rfda_pkg::DIST_ID_B)
		&& (kind_q == 8'h00) && (cnt_q != rfda_pkg::CNT_FULL);

	assign sum_nxt = hit ? sum_q + {8'h00, dhi_q, dlo_q} : sum_q;
	assign cnt_nxt = hit ? cnt_q + 8'd1 : cnt_q;

	assign push           = accept && in.batch_end;
	assign push_data.count = cnt_nxt;
	assign push_data.sum   = sum_nxt;

	// parser next state
	always_comb begin
		phase_nxt = phase_q;
		unique case (phase_q)
			rfda_pkg::PH_HDR1: begin
				phase_nxt = (in.rx_byte == rfda_pkg::HDR_BYTE) ? rfda_pkg::PH_HDR2
					: rfda_pkg::PH_HDR1;
			end
			rfda_pkg::PH_HDR2: begin
				phase_nxt = (in.rx_byte == rfda_pkg::HDR_BYTE) ? rfda_pkg::PH_ID1
					: rfda_pkg::PH_HDR1;
			end
			rfda_pkg::PH_ID1: phase_nxt = rfda_pkg::PH_ID2;
			rfda_pkg::PH_ID2: phase_nxt = rfda_pkg::PH_PAY;
			rfda_pkg::PH_PAY: begin
				phase_nxt = (pos_q == rfda_pkg::POS_LAST) ? rfda_pkg::PH_END1
					: rfda_pkg::PH_PAY;
			end
			rfda_pkg::PH_END1: begin
				phase_nxt = (in.rx_byte == rfda_pkg::END_BYTE) ? rfda_pkg::PH_END2
					: rfda_pkg::PH_HDR1;
			end
			rfda_pkg::PH_END2: phase_nxt = rfda_pkg::PH_HDR1;
			default: phase_nxt = rfda_pkg::PH_HDR1;
		endcase
	end

	// parser and accumulator registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rfda_pkg::PH_HDR1;
			id1_q   <= 8'h00;
			id2_q   <= 8'h00;
			pos_q   <= '0;
			sum_q   <= '0;
			cnt_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			if (phase_q == rfda_pkg::PH_ID1) begin
				id1_q <= in.rx_byte;
			end
			if (phase_q == rfda_pkg::PH_ID2) begin
				id2_q <= in.rx_byte;
				pos_q <= '0;
			end
			if (phase_q == rfda_pkg::PH_PAY) begin
				pos_q <= pos_q + 1'b1;
			end
			if (in.batch_end) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_nxt;
				cnt_q <= cnt_nxt;
			end
		end
	end

	// only the payload bytes a distance frame needs are kept
	always_ff @(posedge clk) begin
		if (accept && phase_q == rfda_pkg::PH_PAY) begin
			if (pos_q == rfda_pkg::POS_KIND) kind_q <= in.rx_byte;
			if (pos_q == rfda_pkg::POS_DHI)  dhi_q  <= in.rx_byte;
			if (pos_q == rfda_pkg::POS_DLO)  dlo_q  <= in.rx_byte;
		end
	end

endmodule

`default_nettype wire

[src/rfda_queue.sv]
// ----------------------------------------------------------------------------
// rfda_queue
// Two-entry queue of batch totals between the parser and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module rfda_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire rfda_pkg::batch_t  push_data,
	input  wire logic              pop,
	output rfda_pkg::batch_t       pop_data,
	output rfda_pkg::qstat_t       qstat
);

	rfda_pkg::batch_t mem_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       fill_q;

	assign qstat.full  = (fill_q == 2'd2);
	assign qstat.empty = (fill_q == 2'd0);
	assign pop_data    = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) fill_q <= fill_q + 2'd1;
			else if (pop && !push) fill_q <= fill_q - 2'd1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

[src/rfda_back.sv]
// ----------------------------------------------------------------------------
// rfda_back
// Mean computation: restoring divider, one quotient bit per cycle, followed
// by the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rfda_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rfda_pkg::qstat_t  qstat,
	input  wire rfda_pkg::batch_t  pop_data,
	output logic                   pop,
	rfda_out_if.source             out
);

	rfda_pkg::back_state_t          state_q, state_nxt;
	logic [rfda_pkg::DvdW-1:0]      dvd_q;
	logic [rfda_pkg::CntW-1:0]      rem_q, div_q;
	logic [rfda_pkg::StepW-1:0]     step_q;
	logic [rfda_pkg::CntW:0]        trial;
	logic                           ge;
	logic                           load_out;
	logic                           out_valid_q;
	logic                           last_step;

	assign trial     = {rem_q, dvd_q[rfda_pkg::DvdW-1]};
	assign ge        = (trial >= {1'b0, div_q});
	assign last_step = (step_q == rfda_pkg::StepW'(rfda_pkg::DvdW - 1));

	// sequencer
	always_comb begin
		state_nxt = state_q;
		pop       = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			rfda_pkg::BK_IDLE: begin
				if (!qstat.empty) begin
					pop       = 1'b1;
					state_nxt = rfda_pkg::BK_DIV;
				end
			end
			rfda_pkg::BK_DIV: begin
				if (last_step) state_nxt = rfda_pkg::BK_DONE;
			end
			rfda_pkg::BK_DONE: begin
				if (!out_valid_q || out.ready) begin
					load_out  = 1'b1;
					state_nxt = rfda_pkg::BK_IDLE;
				end
			end
			default: state_nxt = rfda_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rfda_pkg::BK_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (pop) step_q <= '0;
			else if (state_q == rfda_pkg::BK_DIV) step_q <= step_q + 1'b1;
			if (load_out) out_valid_q <= 1'b1;
			else if (out.ready) out_valid_q <= 1'b0;
		end
	end

	// divider datapath: quotient bits shift in as dividend bits shift out
	always_ff @(posedge clk) begin
		if (pop) begin
			dvd_q <= {pop_data.sum, 8'h00};
			div_q <= pop_data.count;
			rem_q <= '0;
		end else if (state_q == rfda_pkg::BK_DIV) begin
			dvd_q <= {dvd_q[rfda_pkg::DvdW-2:0], ge};
			rem_q <= ge ? rfda_pkg::CntW'(trial - {1'b0, div_q})
				: rfda_pkg::CntW'(trial);
		end
	end

	// result register; empty batch reports zeros
	always_ff @(posedge clk) begin
		if (load_out) begin
			out.reading_valid    <= (div_q != '0);
			out.frames_used      <= div_q;
			out.mean_distance_q8 <= (div_q != '0) ? dvd_q[rfda_pkg::SumW-1:0] : '0;
		end
	end

	assign out.valid = out_valid_q;

endmodule

`default_nettype wire

[src/radar_frame_distance_averager_core.sv]
// path: a batch-end byte's totals go through the queue, the restoring divider and
// the result register; an output that is not ready holds the result back
// throughput: one byte per cycle while the queue has room; the divider takes one batch
// at a time and a two-entry queue absorbs closely spaced batch ends before bytes stall
// reset: arst_n clears parser, totals, queue and output valid; no clearing pass
// ----------------------------------------------------------------------------
// radar_frame_distance_averager_core
// Parses radar frames, averages distance per batch and reports the mean.
// ----------------------------------------------------------------------------
`default_nettype none

module radar_frame_distance_averager_core (
	input  wire logic    clk,
	input  wire logic    arst_n,
	rfda_in_if.sink      in,
	rfda_out_if.source   out
);

	logic              push, pop;
	rfda_pkg::batch_t  push_data, pop_data;
	rfda_pkg::qstat_t  qstat;

	// parser and accumulator
	rfda_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in        (in),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	// batch totals queue
	rfda_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	// divider and result register
	rfda_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.pop_data (pop_data),
		.pop      (pop),
		.out      (out)
	);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full || pop)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("queue read while empty");

	a_valid_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid |-> (out.reading_valid == (out.frames_used != 8'd0)))
		else $error("reading_valid disagrees with frames_used");
`endif

endmodule

`default_nettype wire
